// ===== design/lkc_pkg.sv =====
package lkc_pkg;

    localparam int KeyW    = 64;
    localparam int HandleW = 32;
    localparam int LenW    = 14;
    localparam int SlotW   = 3;
    localparam int StampW  = 32;

    // stamp ceiling and header length saturation limit
    localparam logic [StampW-1:0] STAMP_MAX  = 32'hFFFF_FFFF;
    localparam int unsigned       HEADER_MAX = 8192;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_STORE  = 1'b1;

    // what the datapath does with one entry read back from the table
    typedef logic [2:0] t_eval;
    localparam t_eval EV_NONE  = 3'd0;
    localparam t_eval EV_MATCH = 3'd1;
    localparam t_eval EV_VICT  = 3'd2;
    localparam t_eval EV_MIN   = 3'd3;
    localparam t_eval EV_SUB   = 3'd4;

    typedef struct packed {
        logic               command;
        logic [KeyW-1:0]    key;
        logic [HandleW-1:0] object_handle;
        logic [HandleW-1:0] header_handle;
        logic [LenW-1:0]    header_length;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic [SlotW-1:0]   slot;
        logic [HandleW-1:0] found_object;
        logic [HandleW-1:0] found_header;
        logic [LenW-1:0]    found_length;
    } t_out_item;

    typedef struct packed {
        logic  load;
        logic  rd;
        logic  addr_sel;
        t_eval mode;
        logic  pick_free;
        logic  write_entry;
        logic  stamp;
        logic  clr_idx;
        logic  init_low;
        logic  cap;
        logic  fin_sub;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic is_store;
        logic found;
        logic last_idx;
        logic has_free;
        logic ctr_ge;
        logic out_free;
    } t_sts;

endpackage

// ===== design/lkc_ctrl.sv =====
module lkc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lkc_pkg::t_sts i_sts,
    output lkc_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PICK     = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_SCAN_D   = 4'd3;
    localparam logic [3:0] S_HIT_CHK  = 4'd4;
    localparam logic [3:0] S_FETCH    = 4'd5;
    localparam logic [3:0] S_CAP      = 4'd6;
    localparam logic [3:0] S_WRITE    = 4'd7;
    localparam logic [3:0] S_NORM_CHK = 4'd8;
    localparam logic [3:0] S_MIN      = 4'd9;
    localparam logic [3:0] S_MIN_D    = 4'd10;
    localparam logic [3:0] S_SUB      = 4'd11;
    localparam logic [3:0] S_SUB_D    = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PICK;
                end
            end
            S_PICK: begin
                if (!i_sts.is_store || !i_sts.has_free) begin
                    n_state = S_SCAN;
                end else begin
                    o_cmd.pick_free = 1'b1;
                    n_state         = S_WRITE;
                end
            end
            S_SCAN: begin
                o_cmd.rd   = 1'b1;
                o_cmd.mode = i_sts.is_store ? lkc_pkg::EV_VICT : lkc_pkg::EV_MATCH;
                if (i_sts.last_idx) begin
                    n_state = S_SCAN_D;
                end
            end
            S_SCAN_D: begin
                n_state = i_sts.is_store ? S_WRITE : S_HIT_CHK;
            end
            S_HIT_CHK: begin
                n_state = i_sts.found ? S_FETCH : S_DONE;
            end
            S_FETCH: begin
                o_cmd.rd       = 1'b1;
                o_cmd.addr_sel = 1'b1;
                o_cmd.stamp    = 1'b1;
                n_state        = S_CAP;
            end
            S_CAP: begin
                o_cmd.cap = 1'b1;
                n_state   = S_NORM_CHK;
            end
            S_WRITE: begin
                o_cmd.write_entry = 1'b1;
                o_cmd.stamp       = 1'b1;
                n_state           = S_NORM_CHK;
            end
            S_NORM_CHK: begin
                if (i_sts.ctr_ge) begin
                    o_cmd.clr_idx  = 1'b1;
                    o_cmd.init_low = 1'b1;
                    n_state        = S_MIN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MIN: begin
                o_cmd.rd   = 1'b1;
                o_cmd.mode = lkc_pkg::EV_MIN;
                if (i_sts.last_idx) begin
                    n_state = S_MIN_D;
                end
            end
            S_MIN_D: begin
                o_cmd.clr_idx = 1'b1;
                n_state       = S_SUB;
            end
            S_SUB: begin
                o_cmd.rd   = 1'b1;
                o_cmd.mode = lkc_pkg::EV_SUB;
                if (i_sts.last_idx) begin
                    n_state = S_SUB_D;
                end
            end
            S_SUB_D: begin
                o_cmd.fin_sub = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/lkc_dp.sv =====
module lkc_dp #(
    parameter int ENTRIES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lkc_pkg::t_in_item  i_in_data,
    input  lkc_pkg::t_cmd      i_cmd,
    output lkc_pkg::t_sts      o_sts,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output lkc_pkg::t_out_item o_out_data
);

    localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

    // table memories, one read and one write port each
    logic [lkc_pkg::KeyW-1:0]    r_key_mem   [ENTRIES];
    logic [lkc_pkg::HandleW-1:0] r_obj_mem   [ENTRIES];
    logic [lkc_pkg::HandleW-1:0] r_hdr_mem   [ENTRIES];
    logic [lkc_pkg::LenW-1:0]    r_len_mem   [ENTRIES];
    logic [lkc_pkg::StampW-1:0]  r_stamp_mem [ENTRIES];

    logic [ENTRIES-1:0]          r_valid;
    logic [lkc_pkg::StampW-1:0]  r_ctr;
    lkc_pkg::t_in_item           r_item;
    logic [IdxW-1:0]             r_idx;
    logic [IdxW-1:0]             r_sel;
    logic [lkc_pkg::StampW-1:0]  r_low;
    logic                        r_found;

    logic                        r_ev_vld;
    logic [IdxW-1:0]             r_ev_idx;
    lkc_pkg::t_eval              r_ev_mode;

    logic [lkc_pkg::KeyW-1:0]    r_rd_key;
    logic [lkc_pkg::HandleW-1:0] r_rd_obj;
    logic [lkc_pkg::HandleW-1:0] r_rd_hdr;
    logic [lkc_pkg::LenW-1:0]    r_rd_len;
    logic [lkc_pkg::StampW-1:0]  r_rd_stamp;

    logic [lkc_pkg::HandleW-1:0] r_cap_obj;
    logic [lkc_pkg::HandleW-1:0] r_cap_hdr;
    logic [lkc_pkg::LenW-1:0]    r_cap_len;

    logic                        r_out_vld;
    lkc_pkg::t_out_item          r_out;

    logic [IdxW-1:0]             rd_addr;
    logic [IdxW-1:0]             free_idx;
    logic [lkc_pkg::StampW-1:0]  ctr_inc;
    logic                        ev_valid;
    logic                        key_eq;
    logic                        stamp_lt;
    logic                        stamp_we;
    logic [IdxW-1:0]             stamp_waddr;
    logic [lkc_pkg::StampW-1:0]  stamp_wdata;
    logic [lkc_pkg::LenW-1:0]    len_sat;
    logic [IdxW+2:0]             sel_ext;
    logic                        is_hit;

    assign rd_addr  = i_cmd.addr_sel ? r_sel : r_idx;
    assign ctr_inc  = r_ctr + 32'd1;
    assign ev_valid = r_valid[r_ev_idx];
    assign key_eq   = (r_rd_key == r_item.key);
    assign stamp_lt = (r_rd_stamp < r_low);
    assign len_sat  = (32'(i_in_data.header_length) > lkc_pkg::HEADER_MAX)
                    ? lkc_pkg::LenW'(lkc_pkg::HEADER_MAX) : i_in_data.header_length;
    assign sel_ext  = {3'b000, r_sel};
    assign is_hit   = r_found && (r_item.command == lkc_pkg::CMD_LOOKUP);

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IdxW'(i);
            end
        end
    end

    // stamp port: new stamp on hit or store, rebased stamp during renormalize
    always_comb begin
        stamp_we    = 1'b0;
        stamp_waddr = r_sel;
        stamp_wdata = ctr_inc;
        if (i_cmd.stamp) begin
            stamp_we = 1'b1;
        end else if (r_ev_vld && (r_ev_mode == lkc_pkg::EV_SUB) && ev_valid) begin
            stamp_we    = 1'b1;
            stamp_waddr = r_ev_idx;
            stamp_wdata = r_rd_stamp - r_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_key   <= r_key_mem[rd_addr];
            r_rd_obj   <= r_obj_mem[rd_addr];
            r_rd_hdr   <= r_hdr_mem[rd_addr];
            r_rd_len   <= r_len_mem[rd_addr];
            r_rd_stamp <= r_stamp_mem[rd_addr];
        end
        if (i_cmd.write_entry) begin
            r_key_mem[r_sel] <= r_item.key;
            r_obj_mem[r_sel] <= r_item.object_handle;
            r_hdr_mem[r_sel] <= r_item.header_handle;
            r_len_mem[r_sel] <= r_item.header_length;
        end
        if (stamp_we) begin
            r_stamp_mem[stamp_waddr] <= stamp_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= {i_in_data.command, i_in_data.key, i_in_data.object_handle,
                       i_in_data.header_handle, len_sat};
        end
        if (i_cmd.cap) begin
            r_cap_obj <= r_rd_obj;
            r_cap_hdr <= r_rd_hdr;
            r_cap_len <= r_rd_len;
        end
        if (i_cmd.out_load) begin
            r_out.hit          <= is_hit;
            r_out.slot         <= sel_ext[2:0];
            r_out.found_object <= is_hit ? r_cap_obj : '0;
            r_out.found_header <= is_hit ? r_cap_hdr : '0;
            r_out.found_length <= is_hit ? r_cap_len : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_ctr     <= '0;
            r_idx     <= '0;
            r_sel     <= '0;
            r_low     <= lkc_pkg::STAMP_MAX;
            r_found   <= 1'b0;
            r_ev_vld  <= 1'b0;
            r_ev_idx  <= '0;
            r_ev_mode <= lkc_pkg::EV_NONE;
            r_out_vld <= 1'b0;
        end else begin
            r_ev_vld  <= i_cmd.rd;
            r_ev_idx  <= rd_addr;
            r_ev_mode <= i_cmd.mode;

            if (i_cmd.load) begin
                r_idx   <= '0;
                r_sel   <= '0;
                r_low   <= lkc_pkg::STAMP_MAX;
                r_found <= 1'b0;
            end
            if (i_cmd.rd && !i_cmd.addr_sel) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.clr_idx) begin
                r_idx <= '0;
            end
            if (i_cmd.init_low) begin
                r_low <= lkc_pkg::STAMP_MAX;
            end
            if (i_cmd.pick_free) begin
                r_sel <= free_idx;
            end

            if (r_ev_vld) begin
                case (r_ev_mode)
                    lkc_pkg::EV_MATCH: begin
                        if (!r_found && ev_valid && key_eq) begin
                            r_found <= 1'b1;
                            r_sel   <= r_ev_idx;
                        end
                    end
                    lkc_pkg::EV_VICT: begin
                        if (stamp_lt) begin
                            r_low <= r_rd_stamp;
                            r_sel <= r_ev_idx;
                        end
                    end
                    lkc_pkg::EV_MIN: begin
                        if (ev_valid && stamp_lt) begin
                            r_low <= r_rd_stamp;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (i_cmd.write_entry) begin
                r_valid[r_sel] <= 1'b1;
            end
            if (i_cmd.stamp) begin
                r_ctr <= ctr_inc;
            end else if (i_cmd.fin_sub) begin
                r_ctr <= r_ctr - r_low;
            end

            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_sts.is_store = (r_item.command == lkc_pkg::CMD_STORE);
    assign o_sts.found    = r_found;
    assign o_sts.last_idx = (r_idx == LastIdx);
    assign o_sts.has_free = ~&r_valid;
    assign o_sts.ctr_ge   = (r_ctr >= lkc_pkg::STAMP_MAX);
    assign o_sts.out_free = !r_out_vld || !i_out_stall;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== design/lru_key_cache_table.sv =====
// Item kinds: lookup miss, lookup hit, store into a free slot and store with eviction; a
// renormalize pass (use counter at its maximum) follows a hit or a store when needed.
// The block takes one item at a time: input stays stalled until the result is loaded,
// and the scan reads one entry of the table memory per cycle.
// Reset (synchronous, active low) clears all valid bits, the use counter and the output stage;
// table contents are not cleared, so the block takes items in the first cycle after reset.
module lru_key_cache_table #(
    parameter int ENTRIES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lkc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lkc_pkg::t_out_item o_out_data
);

    // Controller and datapath talk only through these two groups.
    lkc_pkg::t_cmd cmd;
    lkc_pkg::t_sts sts;

    // Sequencer: accept an item, scan for a match or a victim, write or fetch the entry,
    // stamp it, renormalize the stamps when the counter saturates, then hand the result to
    // the output register. Input stays stalled from accept until the result is loaded.
    lkc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Table memories, valid bits, use counter, scan compare logic and the output register.
    // The output register holds a finished item while the next input item is taken.
    lkc_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
